>>> hw/rtl/tahr_pkg.sv
package tahr_pkg;

  localparam int unsigned LEVEL_FRAC_BITS = 23;
  localparam int unsigned LEN_BITS        = 24;
  localparam int unsigned LEVEL_BITS      = LEVEL_FRAC_BITS + 1;
  localparam int unsigned START_BITS      = LEN_BITS + 1;
  localparam int unsigned POS_BITS        = LEN_BITS + 2;
  localparam int unsigned SAMPLE_BITS     = 24;
  localparam int unsigned OUT_BITS        = 25;
  localparam int unsigned NUM_BITS        = LEN_BITS + 1;
  localparam int unsigned DIV_STEPS       = NUM_BITS;
  localparam int unsigned CNT_BITS        = $clog2(DIV_STEPS);
  localparam int unsigned PROD_BITS       = SAMPLE_BITS + LEVEL_BITS + 1;
  localparam int unsigned CFG_IDX_BITS    = 2;

  localparam logic [LEVEL_BITS-1:0] FULL_SCALE = LEVEL_BITS'(1) << LEVEL_FRAC_BITS;
  localparam logic [CNT_BITS-1:0]   DIV_LAST   = CNT_BITS'(DIV_STEPS - 1);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ATTACK_LEN  = 2'd0,
    CFG_HOLD_LEN    = 2'd1,
    CFG_RELEASE_LEN = 2'd2,
    CFG_SIGNAL_MODE = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_LEVEL,
    ST_MUL,
    ST_DONE
  } tahr_state_e;

  typedef struct packed {
    logic capture;
    logic load;
    logic div_step;
    logic calc;
    logic mul;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic [LEN_BITS-1:0] rem;
    logic                qbit;
  } div_res_t;

  function automatic div_res_t div_step(input logic [LEN_BITS-1:0] rem,
                                        input logic                num_bit,
                                        input logic [LEN_BITS-1:0] dvs);
    logic [LEN_BITS:0] trial;
    logic [LEN_BITS:0] diff;
    div_res_t          res;
    trial = {rem, num_bit};
    diff  = trial - {1'b0, dvs};
    if (trial >= {1'b0, dvs}) begin
      res.rem  = diff[LEN_BITS-1:0];
      res.qbit = 1'b1;
    end else begin
      res.rem  = trial[LEN_BITS-1:0];
      res.qbit = 1'b0;
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/tahr_ctrl.sv
module tahr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               trigger_i,
  output logic               in_ready_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output tahr_pkg::dp_cmd_t  cmd_o
);

  tahr_pkg::tahr_state_e state_q, state_d;
  logic [tahr_pkg::CNT_BITS-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      tahr_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = trigger_i ? tahr_pkg::ST_DIV : tahr_pkg::ST_LEVEL;
        end
      end
      tahr_pkg::ST_DIV: begin
        if (cnt_q == tahr_pkg::DIV_LAST) begin
          state_d = tahr_pkg::ST_LEVEL;
        end
      end
      tahr_pkg::ST_LEVEL: state_d = tahr_pkg::ST_MUL;
      tahr_pkg::ST_MUL:   state_d = tahr_pkg::ST_DONE;
      tahr_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = tahr_pkg::ST_IDLE;
        end
      end
      default: state_d = tahr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o     = (state_q == tahr_pkg::ST_IDLE);
    cmd_o.capture  = (state_q == tahr_pkg::ST_IDLE) && in_valid_i;
    cmd_o.load     = (state_q == tahr_pkg::ST_IDLE) && in_valid_i && trigger_i;
    cmd_o.div_step = (state_q == tahr_pkg::ST_DIV);
    cmd_o.calc     = (state_q == tahr_pkg::ST_LEVEL);
    cmd_o.mul      = (state_q == tahr_pkg::ST_MUL);
    cmd_o.commit   = (state_q == tahr_pkg::ST_DONE) && out_free;
    cnt_d          = cnt_q;
    if (cmd_o.load) begin
      cnt_d = '0;
    end else if (cmd_o.div_step) begin
      cnt_d = cnt_q + 1'b1;
    end
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tahr_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> hw/rtl/tahr_datapath.sv
module tahr_datapath (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  tahr_pkg::dp_cmd_t                        cmd_i,
  input  logic                                     cfg_we_i,
  input  logic [tahr_pkg::CFG_IDX_BITS-1:0]        cfg_index_i,
  input  logic [tahr_pkg::LEN_BITS-1:0]            cfg_data_i,
  input  logic signed [tahr_pkg::SAMPLE_BITS-1:0]  in_sample_i,
  output logic signed [tahr_pkg::OUT_BITS-1:0]     out_value_o
);

  localparam int unsigned LB = tahr_pkg::LEN_BITS;
  localparam int unsigned VB = tahr_pkg::LEVEL_BITS;
  localparam int unsigned F  = tahr_pkg::LEVEL_FRAC_BITS;

  logic [LB-1:0] attack_len_q, hold_len_q, release_len_q;
  logic          signal_mode_q;

  logic [tahr_pkg::POS_BITS-1:0]   position_q;
  logic [VB-1:0]                   level_q;
  logic                            armed_q;
  logic [LB-1:0]                   attack_end_q;
  logic [tahr_pkg::START_BITS-1:0] release_start_q;
  logic [tahr_pkg::POS_BITS-1:0]   total_end_q;
  logic [LB-1:0]                   rel_len_q;
  logic [VB-1:0]                   attack_step_q, release_step_q;

  logic [tahr_pkg::NUM_BITS-1:0] att_num_q, rel_num_q;
  logic [LB-1:0]                 att_rem_q, rel_rem_q;

  logic signed [tahr_pkg::SAMPLE_BITS-1:0] sample_q;
  logic [VB-1:0]                           sig_q, sig_d;
  logic signed [tahr_pkg::PROD_BITS-1:0]   prod_q;
  logic signed [tahr_pkg::OUT_BITS-1:0]    out_q, out_d;

  tahr_pkg::div_res_t att_res, rel_res;
  logic [VB-1:0]      att_eff, rel_eff;
  logic [VB:0]        up_sum;

  assign att_res = tahr_pkg::div_step(att_rem_q, att_num_q[tahr_pkg::NUM_BITS-1],
                                      attack_end_q);
  assign rel_res = tahr_pkg::div_step(rel_rem_q, rel_num_q[tahr_pkg::NUM_BITS-1],
                                      rel_len_q);

  assign att_eff = (attack_end_q == '0) ? tahr_pkg::FULL_SCALE : attack_step_q;
  assign rel_eff = (rel_len_q == '0) ? tahr_pkg::FULL_SCALE : release_step_q;
  assign up_sum  = {1'b0, level_q} + {1'b0, att_eff};

  always_comb begin
    if (position_q < tahr_pkg::POS_BITS'(attack_end_q)) begin
      sig_d = (up_sum > {1'b0, tahr_pkg::FULL_SCALE}) ? tahr_pkg::FULL_SCALE
                                                       : up_sum[VB-1:0];
    end else if (position_q < tahr_pkg::POS_BITS'(release_start_q)) begin
      sig_d = tahr_pkg::FULL_SCALE;
    end else if (position_q < total_end_q) begin
      sig_d = (level_q > rel_eff) ? (level_q - rel_eff) : '0;
    end else begin
      sig_d = '0;
    end
  end

  always_comb begin
    if (!armed_q) begin
      out_d = '0;
    end else if (signal_mode_q) begin
      out_d = prod_q[F + tahr_pkg::OUT_BITS - 1:F];
    end else begin
      out_d = tahr_pkg::OUT_BITS'(sig_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_len_q  <= LB'(4800);
      hold_len_q    <= LB'(14400);
      release_len_q <= LB'(9600);
      signal_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (tahr_pkg::cfg_idx_e'(cfg_index_i))
        tahr_pkg::CFG_ATTACK_LEN:  attack_len_q  <= cfg_data_i;
        tahr_pkg::CFG_HOLD_LEN:    hold_len_q    <= cfg_data_i;
        tahr_pkg::CFG_RELEASE_LEN: release_len_q <= cfg_data_i;
        tahr_pkg::CFG_SIGNAL_MODE: signal_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q      <= '0;
      level_q         <= '0;
      armed_q         <= 1'b0;
      attack_end_q    <= '0;
      release_start_q <= '0;
      total_end_q     <= '0;
      rel_len_q       <= '0;
      attack_step_q   <= '0;
      release_step_q  <= '0;
    end else begin
      if (cmd_i.load) begin
        position_q      <= '0;
        armed_q         <= 1'b1;
        attack_end_q    <= attack_len_q;
        release_start_q <= {1'b0, attack_len_q} + {1'b0, hold_len_q};
        rel_len_q       <= release_len_q;
        attack_step_q   <= '0;
        release_step_q  <= '0;
      end else if (cmd_i.div_step) begin
        total_end_q    <= {1'b0, release_start_q} + tahr_pkg::POS_BITS'(rel_len_q);
        attack_step_q  <= {attack_step_q[VB-2:0], att_res.qbit};
        release_step_q <= {release_step_q[VB-2:0], rel_res.qbit};
      end else if (cmd_i.commit && armed_q) begin
        level_q <= sig_q;
        if (position_q != '1) begin
          position_q <= position_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sample_q <= in_sample_i;
    end
    if (cmd_i.load) begin
      att_num_q <= tahr_pkg::NUM_BITS'(tahr_pkg::FULL_SCALE) + tahr_pkg::NUM_BITS'(attack_len_q)
                   - 1'b1;
      rel_num_q <= tahr_pkg::NUM_BITS'(tahr_pkg::FULL_SCALE) + tahr_pkg::NUM_BITS'(release_len_q)
                   - 1'b1;
      att_rem_q <= '0;
      rel_rem_q <= '0;
    end else if (cmd_i.div_step) begin
      att_num_q <= {att_num_q[tahr_pkg::NUM_BITS-2:0], 1'b0};
      rel_num_q <= {rel_num_q[tahr_pkg::NUM_BITS-2:0], 1'b0};
      att_rem_q <= att_res.rem;
      rel_rem_q <= rel_res.rem;
    end
    if (cmd_i.calc) begin
      sig_q <= sig_d;
    end
    if (cmd_i.mul) begin
      prod_q <= sample_q * $signed({1'b0, sig_q});
    end
    if (cmd_i.commit) begin
      out_q <= out_d;
    end
  end

  assign out_value_o = out_q;

endmodule

>>> hw/rtl/triggered_ahr_envelope_unit.sv
// Linear attack-hold-release envelope generator, one audio tick per input
// transaction. An input transaction carries trigger_i and in_sample_i, and
// every input transaction yields exactly one output transaction on
// out_value_o. Registers are written through the cfg channel, which is always
// ready; cfg_index_i selects attack length, hold length, release length or
// signal mode. New lengths take effect at the next trigger, signal mode with
// the next result. A tick without trigger passes the level, multiply and
// done states before the next ready. A triggered tick first passes the
// divide state, where restoring dividers form the attack and release steps
// one quotient bit per cycle. The done state writes the result to an output
// register, which lets a new input transaction be accepted while a result
// still waits; a stalled receiver holds the block in its final step until
// the waiting result is taken.
// Reset restores the register defaults, clears the envelope state and
// leaves the generator disarmed, so every result is 0 until the first trigger.
module triggered_ahr_envelope_unit (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic                                     trigger_i,
  input  logic signed [tahr_pkg::SAMPLE_BITS-1:0]  in_sample_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic signed [tahr_pkg::OUT_BITS-1:0]     out_value_o,
  input  logic                                     cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  logic [tahr_pkg::CFG_IDX_BITS-1:0]        cfg_index_i,
  input  logic [tahr_pkg::LEN_BITS-1:0]            cfg_data_i
);

  tahr_pkg::dp_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  tahr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .trigger_i   (trigger_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  tahr_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_sample_i (in_sample_i),
    .out_value_o (out_value_o)
  );

endmodule
